FILE: rtl/ffra_pkg.sv
// Shared types and constants for the first-fit aligned region allocator.
// No dependencies; imported by every other file of the block.
package ffra_pkg;

   // Internal offset and length width: zone end and merged spans exceed 32 bits
   localparam int BW = 34;
   // Bit counter width for the serial remainder unit
   localparam int DCW = $clog2(BW + 1);
   // A leftover tail must exceed this many bytes to stay free
   localparam int SPLIT_MIN = 64;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOMEM   = 3'd1,
      ST_ZONE    = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_ZONE_BASE     = 2'd0,
      CSR_ZONE_CAPACITY = 2'd1,
      CSR_ALIGNMENT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BW-1:0] off;
      logic [BW-1:0] len;
   } region_type;

   typedef struct packed {
      logic [31:0] off;
      logic [31:0] len;
   } used_type;

   // Datapath micro-operations issued by the controller
   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_F_RD, OP_LATCH, OP_DIV, OP_CALC1, OP_CALC2, OP_CHECK,
      OP_IDX_INC, OP_W_PAD, OP_W_SPLIT, OP_SU_INIT, OP_SU_RD, OP_SU_WR, OP_INS_WR,
      OP_SD_INIT, OP_SD_RD, OP_SD_WR, OP_SD_DONE, OP_USED_WR, OP_U_RD, OP_U_SCAN,
      OP_F_SCAN, OP_JOIN, OP_SUM, OP_W_MERGE, OP_UD_INIT, OP_UD_RD, OP_UD_WR,
      OP_UD_DONE, OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic rel;
      logic idx_lt;
      logic div_last;
      logic fit;
      logic outside;
      logic full;
      logic split;
      logic keep_pad;
      logic u_lt;
      logic u_match;
      logic f_lt;
      logic jn;
      logic jp;
      logic free_full;
      logic su_more;
      logic sd_more;
      logic ud_more;
   } dp_stat_type;

   typedef enum logic [5:0] {
      S_IDLE, S_A_TEST, S_A_RD, S_A_LATCH, S_A_DIV, S_A_CALC1, S_A_CALC2, S_A_CHECK,
      S_A_DECIDE, S_A_NEXT, S_A_WPAD, S_A_STEP, S_A_WSPLIT, S_USED_WR,
      S_R_UTEST, S_R_URD, S_R_USCAN, S_R_FTEST, S_R_FRD, S_R_FSCAN, S_R_JOIN,
      S_R_DECIDE, S_R_SUM, S_R_MERGE,
      S_SU_INIT, S_SU_TEST, S_SU_RD, S_SU_WR, S_INS_WR,
      S_SD_INIT, S_SD_TEST, S_SD_RD, S_SD_WR, S_SD_DONE,
      S_UD_INIT, S_UD_TEST, S_UD_RD, S_UD_WR, S_UD_DONE,
      S_RSP_OK, S_RSP_NOMEM, S_RSP_ZONE, S_RSP_UNKNOWN, S_RSP_FULL
   } state_type;

endpackage

FILE: rtl/ffra_datapath.sv
// Datapath: zone registers, free and used block memories, serial remainder
// unit, fit and merge arithmetic, result registers. Depends on ffra_pkg.
module ffra_datapath #(
   parameter int FREE_ENTRIES = 64,
   parameter int USED_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic                 req_cmd,
   input  logic [31:0]          req_request_size,
   input  logic [31:0]          req_release_offset,
   input  ffra_pkg::dp_cmd_type cmd,
   output ffra_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_granted_offset
);
   import ffra_pkg::*;

   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int FAW = $clog2(FREE_ENTRIES);
   localparam int UCW = $clog2(USED_ENTRIES + 1);
   localparam int UAW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

   // Memories
   region_type free_mem [FREE_ENTRIES];
   used_type   used_mem [USED_ENTRIES];
   region_type free_q_ff;
   used_type   used_q_ff;

   logic             f_we;
   logic [FAW-1:0]   f_waddr, f_raddr;
   region_type       f_wdata;
   logic             u_we;
   logic [UAW-1:0]   u_waddr, u_raddr;
   used_type         u_wdata;

   // Control registers
   logic [31:0]    base_ff, base_in, cap_ff, cap_in;
   logic [8:0]     align_ff, align_in;
   logic [FCW-1:0] free_cnt_ff, free_cnt_in;
   logic [UCW-1:0] used_cnt_ff, used_cnt_in;
   logic           z0_ff, z0_in, rd_zero_ff, rd_zero_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic           rel_ff, rel_in;
   logic [31:0]    size_ff, size_in, ofs_ff, ofs_in;
   logic [FCW-1:0] idx_ff, idx_in, fk_ff, fk_in;
   logic [UCW-1:0] uidx_ff, uidx_in, uk_ff, uk_in;
   region_type     cur_ff, cur_in, prv_ff, prv_in, blk_ff, blk_in;
   logic [8:0]     rem_ff, rem_in, pad_ff, pad_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [BW-1:0]  aligned_ff, aligned_in, need_ff, need_in;
   logic [BW-1:0]  end_ff, end_in, left_ff, left_in, sum_ff, sum_in;
   logic           fit_ff, fit_in, outside_ff, outside_in, split_ff, split_in;
   logic           kp_ff, kp_in, full_ff, full_in, jn_ff, jn_in, jp_ff, jp_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_off_ff, rsp_off_in;

   // Helpers
   region_type     free_rd;
   logic [8:0]     al_eff;
   logic [DCW-1:0] dbit;
   logic [9:0]     dtry;
   logic [BW-1:0]  zone_end;
   logic           free_full, used_full;
   logic [FCW-1:0] idx_dec, fk_dec, fk_inc;
   logic [UCW-1:0] uk_inc;

   // Entry zero reads as the whole zone until rewritten after reset or a zone write
   assign free_rd  = rd_zero_ff ? region_type'{off: {2'b00, base_ff}, len: {2'b00, cap_ff}}
                                : free_q_ff;
   assign al_eff   = (align_ff == 9'd0) ? 9'd1 : align_ff;
   assign dbit     = dcnt_ff - DCW'(1);
   assign dtry     = {rem_ff, cur_ff.off[dbit]};
   assign zone_end = {2'b00, base_ff} + {2'b00, cap_ff};
   assign free_full = free_cnt_ff >= FCW'(FREE_ENTRIES);
   assign used_full = used_cnt_ff >= UCW'(USED_ENTRIES);
   assign idx_dec  = idx_ff - FCW'(1);
   assign fk_dec   = fk_ff - FCW'(1);
   assign fk_inc   = fk_ff + FCW'(1);
   assign uk_inc   = uk_ff + UCW'(1);

   // Status to the controller
   always_comb begin
      stat.rel       = rel_ff;
      stat.idx_lt    = idx_ff < free_cnt_ff;
      stat.div_last  = dcnt_ff == DCW'(1);
      stat.fit       = fit_ff;
      stat.outside   = outside_ff;
      stat.full      = full_ff;
      stat.split     = split_ff;
      stat.keep_pad  = kp_ff;
      stat.u_lt      = uidx_ff < used_cnt_ff;
      stat.u_match   = used_q_ff.off == ofs_ff;
      stat.f_lt      = free_rd.off < blk_ff.off;
      stat.jn        = jn_ff;
      stat.jp        = jp_ff;
      stat.free_full = free_full;
      stat.su_more   = fk_ff > idx_ff;
      stat.sd_more   = ({1'b0, fk_ff} + (FCW+1)'(1)) < {1'b0, free_cnt_ff};
      stat.ud_more   = ({1'b0, uk_ff} + (UCW+1)'(1)) < {1'b0, used_cnt_ff};
   end

   // Micro-operation decode
   always_comb begin
      base_in = base_ff;  cap_in = cap_ff;  align_in = align_ff;
      free_cnt_in = free_cnt_ff;  used_cnt_in = used_cnt_ff;
      z0_in = z0_ff;  rsp_valid_in = 1'b0;
      rel_in = rel_ff;  size_in = size_ff;  ofs_in = ofs_ff;
      idx_in = idx_ff;  fk_in = fk_ff;  uidx_in = uidx_ff;  uk_in = uk_ff;
      cur_in = cur_ff;  prv_in = prv_ff;  blk_in = blk_ff;
      rem_in = rem_ff;  pad_in = pad_ff;  dcnt_in = dcnt_ff;
      aligned_in = aligned_ff;  need_in = need_ff;  end_in = end_ff;
      left_in = left_ff;  sum_in = sum_ff;
      fit_in = fit_ff;  outside_in = outside_ff;  split_in = split_ff;
      kp_in = kp_ff;  full_in = full_ff;  jn_in = jn_ff;  jp_in = jp_ff;
      rsp_status_in = rsp_status_ff;  rsp_off_in = rsp_off_ff;
      f_we = 1'b0;  f_waddr = idx_ff[FAW-1:0];  f_raddr = idx_ff[FAW-1:0];
      f_wdata = cur_ff;
      u_we = 1'b0;  u_waddr = used_cnt_ff[UAW-1:0];  u_raddr = uidx_ff[UAW-1:0];
      u_wdata = used_q_ff;

      unique case (cmd.op)
         OP_LOAD: begin
            rel_in  = req_cmd;
            size_in = req_request_size;
            ofs_in  = req_release_offset;
            idx_in  = '0;
            uidx_in = '0;
         end
         OP_F_RD: f_raddr = idx_ff[FAW-1:0];
         OP_LATCH: begin
            cur_in  = free_rd;
            rem_in  = '0;
            dcnt_in = DCW'(BW);
         end
         // one quotient bit per cycle; only the remainder is kept
         OP_DIV: begin
            if (dtry >= {1'b0, al_eff}) begin
               rem_in = 9'(dtry - {1'b0, al_eff});
            end else begin
               rem_in = dtry[8:0];
            end
            dcnt_in = dbit;
         end
         OP_CALC1: begin
            pad_in     = (rem_ff == 9'd0) ? 9'd0 : (al_eff - rem_ff);
            aligned_in = cur_ff.off + BW'((rem_ff == 9'd0) ? 9'd0 : (al_eff - rem_ff));
            need_in    = {2'b00, size_ff} + BW'((rem_ff == 9'd0) ? 9'd0 : (al_eff - rem_ff));
         end
         OP_CALC2: begin
            fit_in  = cur_ff.len >= need_ff;
            end_in  = aligned_ff + {2'b00, size_ff};
            left_in = cur_ff.len - need_ff;
         end
         OP_CHECK: begin
            outside_in = (aligned_ff < {2'b00, base_ff}) || (end_ff > zone_end) ||
                         (aligned_ff[BW-1:32] != '0);
            split_in   = left_ff > BW'(SPLIT_MIN);
            kp_in      = pad_ff != 9'd0;
            full_in    = used_full ||
                         ((left_ff > BW'(SPLIT_MIN)) && (pad_ff != 9'd0) && free_full);
         end
         OP_IDX_INC: idx_in = idx_ff + FCW'(1);
         OP_W_PAD: begin
            f_we    = 1'b1;
            f_waddr = idx_ff[FAW-1:0];
            f_wdata = '{off: cur_ff.off, len: BW'(pad_ff)};
         end
         OP_W_SPLIT: begin
            f_we    = 1'b1;
            f_waddr = idx_ff[FAW-1:0];
            f_wdata = '{off: end_ff, len: left_ff};
         end
         OP_SU_INIT: fk_in = free_cnt_ff;
         OP_SU_RD:   f_raddr = fk_dec[FAW-1:0];
         OP_SU_WR: begin
            f_we    = 1'b1;
            f_waddr = fk_ff[FAW-1:0];
            f_wdata = free_rd;
            fk_in   = fk_dec;
         end
         OP_INS_WR: begin
            f_we        = 1'b1;
            f_waddr     = idx_ff[FAW-1:0];
            f_wdata     = rel_ff ? blk_ff : region_type'{off: end_ff, len: left_ff};
            free_cnt_in = free_cnt_ff + FCW'(1);
         end
         OP_SD_INIT: fk_in = idx_ff;
         OP_SD_RD:   f_raddr = fk_inc[FAW-1:0];
         OP_SD_WR: begin
            f_we    = 1'b1;
            f_waddr = fk_ff[FAW-1:0];
            f_wdata = free_rd;
            fk_in   = fk_inc;
         end
         OP_SD_DONE: free_cnt_in = free_cnt_ff - FCW'(1);
         OP_USED_WR: begin
            u_we        = 1'b1;
            u_waddr     = used_cnt_ff[UAW-1:0];
            u_wdata     = '{off: aligned_ff[31:0], len: size_ff};
            used_cnt_in = used_cnt_ff + UCW'(1);
         end
         OP_U_RD: u_raddr = uidx_ff[UAW-1:0];
         OP_U_SCAN: begin
            blk_in = '{off: {2'b00, used_q_ff.off}, len: {2'b00, used_q_ff.len}};
            if (used_q_ff.off != ofs_ff) begin
               uidx_in = uidx_ff + UCW'(1);
            end
         end
         // walk free list until an entry at or above the released offset
         OP_F_SCAN: begin
            cur_in = free_rd;
            if (free_rd.off < blk_ff.off) begin
               prv_in = free_rd;
               idx_in = idx_ff + FCW'(1);
            end
         end
         OP_JOIN: begin
            jn_in = (idx_ff < free_cnt_ff) && ((blk_ff.off + blk_ff.len) == cur_ff.off);
            jp_in = (idx_ff != '0) && ((prv_ff.off + prv_ff.len) == blk_ff.off);
         end
         OP_SUM: sum_in = blk_ff.len + (jn_ff ? cur_ff.len : '0);
         OP_W_MERGE: begin
            f_we = 1'b1;
            if (jp_ff) begin
               f_waddr = idx_dec[FAW-1:0];
               f_wdata = '{off: prv_ff.off, len: prv_ff.len + sum_ff};
            end else begin
               f_waddr = idx_ff[FAW-1:0];
               f_wdata = '{off: blk_ff.off, len: sum_ff};
            end
         end
         OP_UD_INIT: uk_in = uidx_ff;
         OP_UD_RD:   u_raddr = uk_inc[UAW-1:0];
         OP_UD_WR: begin
            u_we    = 1'b1;
            u_waddr = uk_ff[UAW-1:0];
            u_wdata = used_q_ff;
            uk_in   = uk_inc;
         end
         OP_UD_DONE: used_cnt_in = used_cnt_ff - UCW'(1);
         OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.code;
            rsp_off_in    = ((cmd.code == ST_OK) && !rel_ff) ? aligned_ff[31:0] : 32'd0;
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase

      // entry zero override ends once the entry is rewritten
      if (f_we && (f_waddr == '0)) begin
         z0_in = 1'b0;
      end
      rd_zero_in = z0_ff && (f_raddr == '0);

      // register writes; a zone write restarts the free list
      if (csr_write_en) begin
         priority case (csr_index)
            CSR_ZONE_BASE: begin
               base_in     = csr_write_data;
               free_cnt_in = FCW'(1);
               z0_in       = 1'b1;
            end
            CSR_ZONE_CAPACITY: begin
               cap_in      = csr_write_data;
               free_cnt_in = FCW'(1);
               z0_in       = 1'b1;
            end
            CSR_ALIGNMENT: align_in = csr_write_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'd0;
         cap_ff       <= 32'd65536;
         align_ff     <= 9'd4;
         free_cnt_ff  <= FCW'(1);
         used_cnt_ff  <= '0;
         z0_ff        <= 1'b1;
         rd_zero_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         cap_ff       <= cap_in;
         align_ff     <= align_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         z0_ff        <= z0_in;
         rd_zero_ff   <= rd_zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rel_ff <= rel_in;  size_ff <= size_in;  ofs_ff <= ofs_in;
      idx_ff <= idx_in;  fk_ff <= fk_in;  uidx_ff <= uidx_in;  uk_ff <= uk_in;
      cur_ff <= cur_in;  prv_ff <= prv_in;  blk_ff <= blk_in;
      rem_ff <= rem_in;  pad_ff <= pad_in;  dcnt_ff <= dcnt_in;
      aligned_ff <= aligned_in;  need_ff <= need_in;  end_ff <= end_in;
      left_ff <= left_in;  sum_ff <= sum_in;
      fit_ff <= fit_in;  outside_ff <= outside_in;  split_ff <= split_in;
      kp_ff <= kp_in;  full_ff <= full_in;  jn_ff <= jn_in;  jp_ff <= jp_in;
      rsp_status_ff <= rsp_status_in;  rsp_off_ff <= rsp_off_in;
   end

   // Free block memory
   always_ff @(posedge clock) begin
      if (f_we) begin
         free_mem[f_waddr] <= f_wdata;
      end
      free_q_ff <= free_mem[f_raddr];
   end

   // Used block memory
   always_ff @(posedge clock) begin
      if (u_we) begin
         used_mem[u_waddr] <= u_wdata;
      end
      used_q_ff <= used_mem[u_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_off_ff;

endmodule

FILE: rtl/ffra_ctrl.sv
// Controller state machine: sequences list scans, remainder steps, list
// shifts and the result. Depends on ffra_pkg.
module ffra_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ffra_pkg::dp_stat_type stat,
   output ffra_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import ffra_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         // release requests branch off right after the request is taken
         S_IDLE:     if (start) state_in = stat.rel ? S_R_UTEST : S_A_TEST;
         S_A_TEST:   state_in = stat.idx_lt ? S_A_RD : S_RSP_NOMEM;
         S_A_RD:     state_in = S_A_LATCH;
         S_A_LATCH:  state_in = S_A_DIV;
         S_A_DIV:    state_in = stat.div_last ? S_A_CALC1 : S_A_DIV;
         S_A_CALC1:  state_in = S_A_CALC2;
         S_A_CALC2:  state_in = S_A_CHECK;
         S_A_CHECK:  state_in = S_A_DECIDE;
         S_A_DECIDE: begin
            priority if (!stat.fit)     state_in = S_A_NEXT;
            else if (stat.outside)      state_in = S_RSP_ZONE;
            else if (stat.full)         state_in = S_RSP_FULL;
            else if (stat.keep_pad)     state_in = S_A_WPAD;
            else if (stat.split)        state_in = S_A_WSPLIT;
            else                        state_in = S_SD_INIT;
         end
         S_A_NEXT:   state_in = S_A_TEST;
         S_A_WPAD:   state_in = stat.split ? S_A_STEP : S_USED_WR;
         S_A_STEP:   state_in = S_SU_INIT;
         S_A_WSPLIT: state_in = S_USED_WR;
         S_USED_WR:  state_in = S_RSP_OK;
         S_R_UTEST:  state_in = stat.u_lt ? S_R_URD : S_RSP_UNKNOWN;
         S_R_URD:    state_in = S_R_USCAN;
         S_R_USCAN:  state_in = stat.u_match ? S_R_FTEST : S_R_UTEST;
         S_R_FTEST:  state_in = stat.idx_lt ? S_R_FRD : S_R_JOIN;
         S_R_FRD:    state_in = S_R_FSCAN;
         S_R_FSCAN:  state_in = stat.f_lt ? S_R_FTEST : S_R_JOIN;
         S_R_JOIN:   state_in = S_R_DECIDE;
         S_R_DECIDE: begin
            if (!stat.jn && !stat.jp && stat.free_full) state_in = S_RSP_FULL;
            else                                        state_in = S_UD_INIT;
         end
         S_R_SUM:    state_in = S_R_MERGE;
         S_R_MERGE:  state_in = (stat.jn && stat.jp) ? S_SD_INIT : S_RSP_OK;
         S_SU_INIT:  state_in = S_SU_TEST;
         S_SU_TEST:  state_in = stat.su_more ? S_SU_RD : S_INS_WR;
         S_SU_RD:    state_in = S_SU_WR;
         S_SU_WR:    state_in = S_SU_TEST;
         S_INS_WR:   state_in = stat.rel ? S_RSP_OK : S_USED_WR;
         S_SD_INIT:  state_in = S_SD_TEST;
         S_SD_TEST:  state_in = stat.sd_more ? S_SD_RD : S_SD_DONE;
         S_SD_RD:    state_in = S_SD_WR;
         S_SD_WR:    state_in = S_SD_TEST;
         S_SD_DONE:  state_in = stat.rel ? S_RSP_OK : S_USED_WR;
         S_UD_INIT:  state_in = S_UD_TEST;
         S_UD_TEST:  state_in = stat.ud_more ? S_UD_RD : S_UD_DONE;
         S_UD_RD:    state_in = S_UD_WR;
         S_UD_WR:    state_in = S_UD_TEST;
         S_UD_DONE:  state_in = (stat.jn || stat.jp) ? S_R_SUM : S_SU_INIT;
         S_RSP_OK, S_RSP_NOMEM, S_RSP_ZONE, S_RSP_UNKNOWN, S_RSP_FULL:
                     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.code = ST_OK;
      unique case (state_ff)
         S_IDLE:     cmd.op = OP_LOAD;
         S_A_RD:     cmd.op = OP_F_RD;
         S_A_LATCH:  cmd.op = OP_LATCH;
         S_A_DIV:    cmd.op = OP_DIV;
         S_A_CALC1:  cmd.op = OP_CALC1;
         S_A_CALC2:  cmd.op = OP_CALC2;
         S_A_CHECK:  cmd.op = OP_CHECK;
         S_A_NEXT:   cmd.op = OP_IDX_INC;
         S_A_WPAD:   cmd.op = OP_W_PAD;
         S_A_STEP:   cmd.op = OP_IDX_INC;
         S_A_WSPLIT: cmd.op = OP_W_SPLIT;
         S_USED_WR:  cmd.op = OP_USED_WR;
         S_R_URD:    cmd.op = OP_U_RD;
         S_R_USCAN:  cmd.op = OP_U_SCAN;
         S_R_FRD:    cmd.op = OP_F_RD;
         S_R_FSCAN:  cmd.op = OP_F_SCAN;
         S_R_JOIN:   cmd.op = OP_JOIN;
         S_R_SUM:    cmd.op = OP_SUM;
         S_R_MERGE:  cmd.op = OP_W_MERGE;
         S_SU_INIT:  cmd.op = OP_SU_INIT;
         S_SU_RD:    cmd.op = OP_SU_RD;
         S_SU_WR:    cmd.op = OP_SU_WR;
         S_INS_WR:   cmd.op = OP_INS_WR;
         S_SD_INIT:  cmd.op = OP_SD_INIT;
         S_SD_RD:    cmd.op = OP_SD_RD;
         S_SD_WR:    cmd.op = OP_SD_WR;
         S_SD_DONE:  cmd.op = OP_SD_DONE;
         S_UD_INIT:  cmd.op = OP_UD_INIT;
         S_UD_RD:    cmd.op = OP_UD_RD;
         S_UD_WR:    cmd.op = OP_UD_WR;
         S_UD_DONE:  cmd.op = OP_UD_DONE;
         S_RSP_OK: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_OK;
         end
         S_RSP_NOMEM: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_NOMEM;
         end
         S_RSP_ZONE: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_ZONE;
         end
         S_RSP_UNKNOWN: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_UNKNOWN;
         end
         S_RSP_FULL: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_FULL;
         end
         default:    cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

FILE: rtl/first_fit_aligned_region_allocator.sv
// Top level of the first-fit aligned region allocator: controller plus datapath.
// Depends on ffra_pkg, ffra_ctrl and ffra_datapath.
//
//  channel   ports                                           direction  handshake
//  request   start, busy, req_cmd, req_request_size,         in         start & !busy
//            req_release_offset
//  result    rsp_valid, rsp_status, rsp_granted_offset       out        rsp_valid, 1 cycle
//  csr       csr_write_en, csr_index, csr_write_data         in         csr_write_en
//
// An allocate works out, for every free block it examines, the bit-serial
// remainder of the block start by the alignment.
// A release searches the used entries and walks the free entries.
// Each entry moved by a list insert or erase is read and then written one slot along.
// The result strobe follows the last cycle of busy; reset is synchronous and
// needs no clearing pass. The result cannot be held off by the receiver.
module first_fit_aligned_region_allocator #(
   parameter int FREE_ENTRIES = 64,
   parameter int USED_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_release_offset,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_offset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import ffra_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   dp_stat_type ctrl_stat;

   // the controller sees the command of a request at the edge it is taken
   always_comb begin
      ctrl_stat     = stat;
      ctrl_stat.rel = busy ? stat.rel : req_cmd;
   end

   ffra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (ctrl_stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ffra_datapath #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .USED_ENTRIES (USED_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_cmd            (req_cmd),
      .req_request_size   (req_request_size),
      .req_release_offset (req_release_offset),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

endmodule

FILE: rtl/ffra_checker.sv
// Port-level checks for the first-fit aligned region allocator, bound to the top.
// Depends on ffra_pkg.
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_granted_offset
);
   import ffra_pkg::*;

   // an accepted transaction keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a result only closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe outside the end of a transaction");

   // one result per transaction
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // only a successful transaction carries an offset
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_granted_offset == 32'd0))
      else $error("nonzero offset on failed transaction");

   // status codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_OK) || (rsp_status == ST_NOMEM) ||
                     (rsp_status == ST_ZONE) || (rsp_status == ST_UNKNOWN) ||
                     (rsp_status == ST_FULL)))
      else $error("undefined status code");

endmodule

bind first_fit_aligned_region_allocator ffra_checker u_ffra_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_granted_offset (rsp_granted_offset)
);
